[rtl/point_segment_distance_3d_defines.svh]
// Assertion macros shared by the checker of point_segment_distance_3d.
// Needs clk_i and rst_ni in the scope where a macro is used.
`ifndef POINT_SEGMENT_DISTANCE_3D_DEFINES_SVH
`define POINT_SEGMENT_DISTANCE_3D_DEFINES_SVH

// Clocked check, off while reset is asserted.
`define PSD3_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// Clocked check that also holds while reset is asserted.
`define PSD3_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) (prop)) else $error(msg);

`endif

[rtl/psd3_pkg.sv]
// Shared types for point_segment_distance_3d.
// No dependencies.
`default_nettype none
package psd3_pkg;

  typedef enum logic [1:0] {
    REGION_A   = 2'd0,
    REGION_B   = 2'd1,
    REGION_MID = 2'd2
  } region_e;

endpackage
`default_nettype wire

[rtl/point_segment_distance_3d.sv]
// Distance from a 3D point P to segment A-B, floor(sqrt(2^(2*FRAC_BITS)*N/D)),
// with the nearest region (endpoint A, endpoint B or interior). Fully pipelined:
// one query per clock while the output is not stalled, through the front
// pipeline, the bit-per-stage divider and square root. Every stage
// holds its own valid bit, so bubbles close up under back-pressure.
// Depends on psd3_pkg, psd3_prep, psd3_div, psd3_sqrt.
`default_nettype none
module point_segment_distance_3d #(
  parameter int COORD_WIDTH = 16,
  parameter int FRAC_BITS   = 8
) (
  input  wire logic                                clk_i,
  input  wire logic                                rst_ni,
  input  wire logic                                s_axis_tvalid_i,
  output logic                                     s_axis_tready_o,
  // point_x, point_y, point_z, seg_a_x..z, seg_b_x..z, from bit 0 up
  input  wire logic [((9*COORD_WIDTH+7)/8)*8-1:0]  s_axis_tdata_i,
  output logic                                     m_axis_tvalid_o,
  input  wire logic                                m_axis_tready_i,
  // distance, nearest_region, from bit 0 up
  output logic [((COORD_WIDTH+FRAC_BITS+3+7)/8)*8-1:0] m_axis_tdata_o
);
  import psd3_pkg::*;

  localparam int CW   = COORD_WIDTH;
  localparam int OW   = COORD_WIDTH + FRAC_BITS + 1;
  localparam int QW   = 2 * OW;
  localparam int MW   = 2 * (CW + 1) + 1;
  localparam int NW   = 2 * MW + 2;
  localparam int DENW = 2 * (CW + 1) + 2;
  localparam int MDW  = ((OW + 2 + 7) / 8) * 8;

  logic            pr_valid, pr_ready, dv_valid, dv_ready, sq_valid;
  logic [NW-1:0]   pr_n;
  logic [DENW-1:0] pr_d;
  logic [QW-1:0]   dv_q;
  logic [OW-1:0]   sq_root;
  region_e         pr_region, dv_region, sq_region;

  psd3_prep #(.CW(CW), .NW(NW), .DENW(DENW)) u_prep (
    .clk_i, .rst_ni,
    .in_valid_i  (s_axis_tvalid_i),
    .in_ready_o  (s_axis_tready_o),
    .p_i         (s_axis_tdata_i[3*CW-1:0]),
    .a_i         (s_axis_tdata_i[6*CW-1:3*CW]),
    .b_i         (s_axis_tdata_i[9*CW-1:6*CW]),
    .out_valid_o (pr_valid),
    .out_ready_i (pr_ready),
    .n_o         (pr_n),
    .d_o         (pr_d),
    .region_o    (pr_region)
  );

  psd3_div #(.NW(NW), .DENW(DENW), .QW(QW), .SHW(2*FRAC_BITS)) u_div (
    .clk_i, .rst_ni,
    .in_valid_i  (pr_valid),
    .in_ready_o  (pr_ready),
    .n_i         (pr_n),
    .d_i         (pr_d),
    .region_i    (pr_region),
    .out_valid_o (dv_valid),
    .out_ready_i (dv_ready),
    .q_o         (dv_q),
    .region_o    (dv_region)
  );

  psd3_sqrt #(.OW(OW)) u_sqrt (
    .clk_i, .rst_ni,
    .in_valid_i  (dv_valid),
    .in_ready_o  (dv_ready),
    .x_i         (dv_q),
    .region_i    (dv_region),
    .out_valid_o (sq_valid),
    .out_ready_i (m_axis_tready_i),
    .root_o      (sq_root),
    .region_o    (sq_region)
  );

  assign m_axis_tvalid_o = sq_valid;
  assign m_axis_tdata_o  = MDW'({sq_region, sq_root});

endmodule
`default_nettype wire

[rtl/psd3_prep.sv]
// Front pipeline: differences, dot and cross products, region choice, N and D.
// Depends on psd3_pkg.
`default_nettype none
module psd3_prep #(
  parameter int CW   = 16,
  parameter int NW   = 72,
  parameter int DENW = 36
) (
  input  wire logic                    clk_i,
  input  wire logic                    rst_ni,
  input  wire logic                    in_valid_i,
  output logic                         in_ready_o,
  input  wire logic [3*CW-1:0]         p_i,
  input  wire logic [3*CW-1:0]         a_i,
  input  wire logic [3*CW-1:0]         b_i,
  output logic                         out_valid_o,
  input  wire logic                    out_ready_i,
  output logic [NW-1:0]                n_o,
  output logic [DENW-1:0]              d_o,
  output psd3_pkg::region_e            region_o
);
  import psd3_pkg::*;

  localparam int S    = 7;
  localparam int DW   = CW + 1;
  localparam int PW   = 2 * DW;
  localparam int DOTW = PW + 2;
  localparam int MW   = PW + 1;
  localparam int H    = (MW + 1) / 2;
  localparam int HHW  = 2 * (MW - H);
  localparam int LLW  = 2 * H;
  localparam int SQW  = 2 * MW;

  logic [S-1:0] vld_q;
  logic [S:0]   rdy;
  logic [S-1:0] vld_in;

  always_comb begin
    rdy[S] = out_ready_i;
    for (int k = S - 1; k >= 0; k--) begin
      rdy[k] = !vld_q[k] || rdy[k+1];
    end
  end
  assign vld_in = {vld_q[S-2:0], in_valid_i};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else begin
      for (int k = 0; k < S; k++) begin
        if (rdy[k]) vld_q[k] <= vld_in[k];
      end
    end
  end

  // stage 1: U = B-A, W = P-A, V = P-B
  logic signed [DW-1:0] u_q [3], w_q [3], v_q [3];
  always_ff @(posedge clk_i) begin
    if (rdy[0]) begin
      for (int k = 0; k < 3; k++) begin
        u_q[k] <= DW'($signed(b_i[k*CW +: CW])) - DW'($signed(a_i[k*CW +: CW]));
        w_q[k] <= DW'($signed(p_i[k*CW +: CW])) - DW'($signed(a_i[k*CW +: CW]));
        v_q[k] <= DW'($signed(p_i[k*CW +: CW])) - DW'($signed(b_i[k*CW +: CW]));
      end
    end
  end

  // stage 2: all products
  logic signed [PW-1:0] duw_q [3], duv_q [3], pa_q [3], pb_q [3];
  logic signed [PW-1:0] uu_q [3], ww_q [3], vv_q [3];
  always_ff @(posedge clk_i) begin
    if (rdy[1]) begin
      for (int k = 0; k < 3; k++) begin
        duw_q[k] <= PW'(u_q[k]) * PW'(w_q[k]);
        duv_q[k] <= PW'(u_q[k]) * PW'(v_q[k]);
        pa_q[k]  <= PW'(u_q[(k+1)%3]) * PW'(w_q[(k+2)%3]);
        pb_q[k]  <= PW'(u_q[(k+2)%3]) * PW'(w_q[(k+1)%3]);
        uu_q[k]  <= PW'(u_q[k]) * PW'(u_q[k]);
        ww_q[k]  <= PW'(w_q[k]) * PW'(w_q[k]);
        vv_q[k]  <= PW'(v_q[k]) * PW'(v_q[k]);
      end
    end
  end

  // stage 3: dot products, cross product, squared lengths
  logic signed [DOTW-1:0] dotw_q, dotv_q;
  logic signed [MW-1:0]   c_q [3];
  logic [DENW-1:0]        den_q, ew_q, ev_q;
  always_ff @(posedge clk_i) begin
    if (rdy[2]) begin
      dotw_q <= DOTW'(duw_q[0]) + DOTW'(duw_q[1]) + DOTW'(duw_q[2]);
      dotv_q <= DOTW'(duv_q[0]) + DOTW'(duv_q[1]) + DOTW'(duv_q[2]);
      for (int k = 0; k < 3; k++) begin
        c_q[k] <= MW'(pa_q[k]) - MW'(pb_q[k]);
      end
      den_q <= DENW'($unsigned(uu_q[0])) + DENW'($unsigned(uu_q[1]))
             + DENW'($unsigned(uu_q[2]));
      ew_q  <= DENW'($unsigned(ww_q[0])) + DENW'($unsigned(ww_q[1]))
             + DENW'($unsigned(ww_q[2]));
      ev_q  <= DENW'($unsigned(vv_q[0])) + DENW'($unsigned(vv_q[1]))
             + DENW'($unsigned(vv_q[2]));
    end
  end

  // stage 4: region; degenerate segment (D == 0) counts as endpoint A
  region_e         region_d, reg4_q, reg5_q, reg6_q;
  logic [MW-1:0]   mag_q [3];
  logic [DENW-1:0] den4_q, end4_q, den5_q, end5_q, den6_q, end6_q;
  always_comb begin
    if (den_q == '0 || dotw_q < 0)      region_d = REGION_A;
    else if (dotv_q > 0)                region_d = REGION_B;
    else                                region_d = REGION_MID;
  end
  always_ff @(posedge clk_i) begin
    if (rdy[3]) begin
      reg4_q <= region_d;
      den4_q <= den_q;
      end4_q <= (region_d == REGION_A) ? ew_q : ev_q;
      for (int k = 0; k < 3; k++) begin
        mag_q[k] <= c_q[k][MW-1] ? MW'(-c_q[k]) : MW'(c_q[k]);
      end
    end
  end

  // stage 5: split squares of the cross components
  logic [HHW-1:0] hh_q [3];
  logic [MW-1:0]  hl_q [3];
  logic [LLW-1:0] ll_q [3];
  always_ff @(posedge clk_i) begin
    if (rdy[4]) begin
      reg5_q <= reg4_q;
      den5_q <= den4_q;
      end5_q <= end4_q;
      for (int k = 0; k < 3; k++) begin
        hh_q[k] <= HHW'(mag_q[k][MW-1:H]) * HHW'(mag_q[k][MW-1:H]);
        hl_q[k] <= MW'(mag_q[k][MW-1:H]) * MW'(mag_q[k][H-1:0]);
        ll_q[k] <= LLW'(mag_q[k][H-1:0]) * LLW'(mag_q[k][H-1:0]);
      end
    end
  end

  // stage 6: recombine squares
  logic [SQW-1:0] sq_q [3];
  always_ff @(posedge clk_i) begin
    if (rdy[5]) begin
      reg6_q <= reg5_q;
      den6_q <= den5_q;
      end6_q <= end5_q;
      for (int k = 0; k < 3; k++) begin
        sq_q[k] <= (SQW'(hh_q[k]) << (2 * H)) + (SQW'(hl_q[k]) << (H + 1))
                 + SQW'(ll_q[k]);
      end
    end
  end

  // stage 7: N and D; endpoints divide by one
  logic [NW-1:0]   n_q;
  logic [DENW-1:0] d_q;
  region_e         reg7_q;
  always_ff @(posedge clk_i) begin
    if (rdy[6]) begin
      reg7_q <= reg6_q;
      if (reg6_q == REGION_MID) begin
        n_q <= NW'(sq_q[0]) + NW'(sq_q[1]) + NW'(sq_q[2]);
        d_q <= den6_q;
      end else begin
        n_q <= NW'(end6_q);
        d_q <= DENW'(1);
      end
    end
  end

  assign in_ready_o  = rdy[0];
  assign out_valid_o = vld_q[S-1];
  assign n_o         = n_q;
  assign d_o         = d_q;
  assign region_o    = reg7_q;

endmodule
`default_nettype wire

[rtl/psd3_div.sv]
// Pipelined restoring divider, one quotient bit per stage: Q = (N << SHW) / D.
// Depends on psd3_pkg.
`default_nettype none
module psd3_div #(
  parameter int NW   = 72,
  parameter int DENW = 36,
  parameter int QW   = 50,
  parameter int SHW  = 16
) (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              in_valid_i,
  output logic                   in_ready_o,
  input  wire logic [NW-1:0]     n_i,
  input  wire logic [DENW-1:0]   d_i,
  input  wire psd3_pkg::region_e region_i,
  output logic                   out_valid_o,
  input  wire logic              out_ready_i,
  output logic [QW-1:0]          q_o,
  output psd3_pkg::region_e      region_o
);
  import psd3_pkg::*;

  localparam int XW = NW + SHW;

  logic [QW-1:0] vld_q;
  logic [QW:0]   rdy;
  logic [QW-1:0] vld_in;
  logic [XW-1:0] dvd;

  always_comb begin
    rdy[QW] = out_ready_i;
    for (int k = QW - 1; k >= 0; k--) begin
      rdy[k] = !vld_q[k] || rdy[k+1];
    end
  end
  assign vld_in = {vld_q[QW-2:0], in_valid_i};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else begin
      for (int k = 0; k < QW; k++) begin
        if (rdy[k]) vld_q[k] <= vld_in[k];
      end
    end
  end

  assign dvd = XW'(n_i) << SHW;

  logic [DENW-1:0] rem_q [QW];
  logic [DENW-1:0] dd_q  [QW];
  logic [QW-1:0]   q_q   [QW];
  logic [QW-1:0]   lo_q  [QW];
  region_e         reg_q [QW];

  for (genvar k = 0; k < QW; k++) begin : g_stage
    logic [DENW-1:0] rem_p, d_p, rem_d;
    logic [QW-1:0]   q_p, lo_p;
    region_e         reg_p;
    logic [DENW:0]   t;
    logic            ge;
    if (k == 0) begin : g_first
      // top part is below D because the quotient fits QW bits
      assign rem_p = dvd[QW+DENW-1:QW];
      assign lo_p  = dvd[QW-1:0];
      assign q_p   = '0;
      assign d_p   = d_i;
      assign reg_p = region_i;
    end else begin : g_next
      assign rem_p = rem_q[k-1];
      assign lo_p  = lo_q[k-1];
      assign q_p   = q_q[k-1];
      assign d_p   = dd_q[k-1];
      assign reg_p = reg_q[k-1];
    end
    assign t     = {rem_p, lo_p[QW-1]};
    assign ge    = t >= {1'b0, d_p};
    assign rem_d = ge ? DENW'(t - {1'b0, d_p}) : DENW'(t);
    always_ff @(posedge clk_i) begin
      if (rdy[k]) begin
        rem_q[k] <= rem_d;
        lo_q[k]  <= lo_p << 1;
        q_q[k]   <= {q_p[QW-2:0], ge};
        dd_q[k]  <= d_p;
        reg_q[k] <= reg_p;
      end
    end
  end

  assign in_ready_o  = rdy[0];
  assign out_valid_o = vld_q[QW-1];
  assign q_o         = q_q[QW-1];
  assign region_o    = reg_q[QW-1];

endmodule
`default_nettype wire

[rtl/psd3_sqrt.sv]
// Pipelined integer square root, one root bit per stage (floor).
// Depends on psd3_pkg.
`default_nettype none
module psd3_sqrt #(
  parameter int OW = 25
) (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              in_valid_i,
  output logic                   in_ready_o,
  input  wire logic [2*OW-1:0]   x_i,
  input  wire psd3_pkg::region_e region_i,
  output logic                   out_valid_o,
  input  wire logic              out_ready_i,
  output logic [OW-1:0]          root_o,
  output psd3_pkg::region_e      region_o
);
  import psd3_pkg::*;

  localparam int XW = 2 * OW;

  logic [OW-1:0] vld_q;
  logic [OW:0]   rdy;
  logic [OW-1:0] vld_in;

  always_comb begin
    rdy[OW] = out_ready_i;
    for (int k = OW - 1; k >= 0; k--) begin
      rdy[k] = !vld_q[k] || rdy[k+1];
    end
  end
  assign vld_in = {vld_q[OW-2:0], in_valid_i};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else begin
      for (int k = 0; k < OW; k++) begin
        if (rdy[k]) vld_q[k] <= vld_in[k];
      end
    end
  end

  logic [OW:0]   rem_q  [OW];
  logic [OW-1:0] root_q [OW];
  logic [XW-1:0] xs_q   [OW];
  region_e       reg_q  [OW];

  for (genvar k = 0; k < OW; k++) begin : g_stage
    logic [OW:0]   rem_p, rem_d;
    logic [OW-1:0] root_p;
    logic [XW-1:0] xs_p;
    region_e       reg_p;
    logic [OW+2:0] t, trial;
    logic          ge;
    if (k == 0) begin : g_first
      assign rem_p  = '0;
      assign root_p = '0;
      assign xs_p   = x_i;
      assign reg_p  = region_i;
    end else begin : g_next
      assign rem_p  = rem_q[k-1];
      assign root_p = root_q[k-1];
      assign xs_p   = xs_q[k-1];
      assign reg_p  = reg_q[k-1];
    end
    assign t     = {rem_p, xs_p[XW-1:XW-2]};
    assign trial = {1'b0, root_p, 2'b01};
    assign ge    = t >= trial;
    assign rem_d = ge ? (OW+1)'(t - trial) : (OW+1)'(t);
    always_ff @(posedge clk_i) begin
      if (rdy[k]) begin
        rem_q[k]  <= rem_d;
        root_q[k] <= {root_p[OW-2:0], ge};
        xs_q[k]   <= xs_p << 2;
        reg_q[k]  <= reg_p;
      end
    end
  end

  assign in_ready_o  = rdy[0];
  assign out_valid_o = vld_q[OW-1];
  assign root_o      = root_q[OW-1];
  assign region_o    = reg_q[OW-1];

endmodule
`default_nettype wire

[rtl/psd3_checker.sv]
// Port-level checks for point_segment_distance_3d, bound to the top level.
// Depends on point_segment_distance_3d_defines.svh and psd3_pkg.
`default_nettype none
`include "point_segment_distance_3d_defines.svh"
module psd3_checker #(
  parameter int COORD_WIDTH = 16,
  parameter int FRAC_BITS   = 8
) (
  input wire logic                                    clk_i,
  input wire logic                                    rst_ni,
  input wire logic                                    s_axis_tvalid_i,
  input wire logic                                    s_axis_tready_o,
  input wire logic [((9*COORD_WIDTH+7)/8)*8-1:0]      s_axis_tdata_i,
  input wire logic                                    m_axis_tvalid_o,
  input wire logic                                    m_axis_tready_i,
  input wire logic [((COORD_WIDTH+FRAC_BITS+3+7)/8)*8-1:0] m_axis_tdata_o
);
  import psd3_pkg::*;

  localparam int OW = COORD_WIDTH + FRAC_BITS + 1;

  logic [1:0] region;
  assign region = m_axis_tdata_o[OW+1:OW];

  // a stalled result transfer keeps its payload
  `PSD3_ASSERT(a_out_hold, m_axis_tvalid_o && !m_axis_tready_i |=> $stable(m_axis_tdata_o), "result changed while stalled")
  // nearest region carries one of its three codes
  `PSD3_ASSERT(a_region_code, m_axis_tvalid_o |-> (region == REGION_A || region == REGION_B || region == REGION_MID), "bad region code")
  // an empty output stage frees the whole pipeline
  `PSD3_ASSERT(a_ready_when_empty, !m_axis_tvalid_o |-> s_axis_tready_o, "input stalled with empty output")
  // nothing comes out right after reset
  `PSD3_ASSERT_ALWAYS(a_reset_empty, !rst_ni |=> !m_axis_tvalid_o, "result valid after reset")

endmodule

bind point_segment_distance_3d psd3_checker #(
  .COORD_WIDTH(COORD_WIDTH),
  .FRAC_BITS  (FRAC_BITS)
) u_psd3_checker (.*);
`default_nettype wire
